// ===== rtl/turnaround_greedy_worker_assign_macros.svh =====
// Assertion macros shared by the RTL of the worker assignment block.
`ifndef TURNAROUND_GREEDY_WORKER_ASSIGN_MACROS_SVH
`define TURNAROUND_GREEDY_WORKER_ASSIGN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGWA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tgwa_pkg.sv =====
package tgwa_pkg;

    localparam int NUM_WORKERS = 8;
    localparam int BATCH_MAX   = 256;

    localparam int W_ADDR  = $clog2(NUM_WORKERS);
    localparam int SCORE_W = 16;
    localparam int CNT_W   = $clog2(BATCH_MAX + 1);
    localparam int K_W     = $clog2(BATCH_MAX + 3);
    localparam int WT_W    = $clog2((BATCH_MAX + 1) * (BATCH_MAX + 2) + 1);
    localparam int PROD_W  = WT_W + SCORE_W;
    localparam int WID_W   = 4;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_FLUSH  = 3'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_PRESET  = 2'd1,
        ST_BAD_KIND   = 2'd2,
        ST_NONE_AVAIL = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_SCORE = 1'b0,
        FUNC_TASK  = 1'b1
    } t_func;

    typedef struct packed {
        logic               func;
        logic [2:0]         score_worker;
        logic [SCORE_W-1:0] score;
        logic               first_of_batch;
        logic [2:0]         task_kind;
        logic [WID_W-1:0]   preset_worker;
    } t_in_word;

    typedef struct packed {
        logic [WID_W-1:0] assigned_worker;
        t_status          status;
    } t_out_word;

endpackage

// ===== rtl/tgwa_ram.sv =====
module tgwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/turnaround_greedy_worker_assign.sv =====
// A score update is taken while idle and gives no word.
// A task scans the workers in turn through S_WT (weight multiply), S_MUL (cross
// products) and S_CMP (compare), then registers its word in S_DONE once the output
// is free; no new item is taken until the block is back in S_IDLE after that.
// Reset is synchronous and active low: per-entry valid bits make every score and
// count read as zero at once, so no clearing pass follows reset.
`include "turnaround_greedy_worker_assign_macros.svh"

module turnaround_greedy_worker_assign (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tgwa_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output tgwa_pkg::t_out_word o_data
);

    import tgwa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WT,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [W_ADDR-1:0]   r_widx;
    logic                r_spd_vld [NUM_WORKERS];
    logic                r_cnt_vld [NUM_WORKERS];
    logic                r_rd_spd_vld;
    logic                r_rd_cnt_vld;
    logic [2:0]          r_kind;
    logic [WID_W-1:0]    r_preset;
    logic [SCORE_W-1:0]  r_s;
    logic [CNT_W-1:0]    r_cnt;
    logic [WT_W-1:0]     r_wt;
    logic [PROD_W-1:0]   r_p_new;
    logic [PROD_W-1:0]   r_p_best;
    logic                r_best_valid;
    logic [W_ADDR-1:0]   r_best_idx;
    logic [WT_W-1:0]     r_best_wt;
    logic [SCORE_W-1:0]  r_best_s;
    logic [CNT_W-1:0]    r_best_cnt;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                accept;
    logic                accept_task;
    logic                accept_score;
    logic                last_worker;
    logic                out_free;
    logic                rd_en;
    logic [W_ADDR-1:0]   rd_addr;
    logic                rd_cnt_vld;
    logic [SCORE_W-1:0]  spd_rdata;
    logic [CNT_W-1:0]    cnt_rdata;
    logic                spd_we;
    logic [W_ADDR-1:0]   spd_waddr;
    logic                cnt_we;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [SCORE_W-1:0]  n_s;
    logic [CNT_W-1:0]    n_cnt;
    logic [K_W-1:0]      n_k;
    logic [K_W-1:0]      n_k1;
    logic [2*K_W-1:0]    n_kk;
    logic [WT_W-1:0]     n_wt;
    logic [PROD_W-1:0]   n_p_new;
    logic [PROD_W-1:0]   n_p_best;
    logic                n_better;
    logic                has_preset;
    t_out_word           n_out;

    assign o_ready      = (r_state == S_IDLE);
    assign accept       = i_valid && o_ready;
    assign accept_task  = accept && (i_data.func == FUNC_TASK);
    assign accept_score = accept && (i_data.func == FUNC_SCORE);
    assign last_worker  = (r_widx == W_ADDR'(NUM_WORKERS - 1));
    assign out_free     = !r_out_valid || i_ready;

    assign rd_en      = accept_task || (r_state == S_CMP && !last_worker);
    assign rd_addr    = accept_task ? '0 : r_widx + 1'b1;
    assign rd_cnt_vld = r_cnt_vld[rd_addr] && !(accept_task && i_data.first_of_batch);

    assign spd_we    = accept_score && (i_data.score_worker < NUM_WORKERS);
    assign spd_waddr = W_ADDR'(i_data.score_worker);

    assign cnt_we    = (r_state == S_DONE) && out_free && r_best_valid;
    assign cnt_wdata = (r_best_cnt < CNT_W'(BATCH_MAX)) ? r_best_cnt + 1'b1 : r_best_cnt;

    tgwa_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (NUM_WORKERS)
    ) u_speed_ram (
        .i_clk   (i_clk),
        .i_we    (spd_we),
        .i_waddr (spd_waddr),
        .i_wdata (i_data.score),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (spd_rdata)
    );

    tgwa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_WORKERS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_best_idx),
        .i_wdata (cnt_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    always_comb begin
        n_s      = r_rd_spd_vld ? spd_rdata : '0;
        n_cnt    = r_rd_cnt_vld ? cnt_rdata : '0;
        n_k      = K_W'(n_cnt) + 1'b1;
        n_k1     = n_k + 1'b1;
        n_kk     = {{K_W{1'b0}}, n_k} * {{K_W{1'b0}}, n_k1};
        n_wt     = n_kk[WT_W-1:0];
        n_p_new  = {{SCORE_W{1'b0}}, r_wt} * {{WT_W{1'b0}}, r_best_s};
        n_p_best = {{SCORE_W{1'b0}}, r_best_wt} * {{WT_W{1'b0}}, r_s};
        n_better = (r_s != '0) && (!r_best_valid || r_p_new < r_p_best);
    end

    always_comb begin
        has_preset = (r_preset != '0) && (r_preset <= NUM_WORKERS);
        n_out.assigned_worker = '0;
        n_out.status          = ST_OK;
        if (r_kind > KIND_FLUSH) begin
            n_out.status = ST_BAD_KIND;
        end else if (has_preset) begin
            n_out.assigned_worker = r_preset;
        end else if (r_kind inside {KIND_DELETE, KIND_FLUSH}) begin
            n_out.status = ST_NO_PRESET;
        end else if (!r_best_valid) begin
            n_out.status = ST_NONE_AVAIL;
        end else begin
            n_out.assigned_worker = WID_W'(r_best_idx) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_widx       <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_spd_vld[i] <= 1'b0;
                r_cnt_vld[i] <= 1'b0;
            end
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                r_rd_spd_vld <= r_spd_vld[rd_addr];
                r_rd_cnt_vld <= rd_cnt_vld;
            end
            if (spd_we) begin
                r_spd_vld[spd_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept_task) begin
                        r_kind       <= i_data.task_kind;
                        r_preset     <= i_data.preset_worker;
                        r_widx       <= '0;
                        r_best_valid <= 1'b0;
                        if (i_data.first_of_batch) begin
                            for (int i = 0; i < NUM_WORKERS; i++) begin
                                r_cnt_vld[i] <= 1'b0;
                            end
                        end
                        r_state <= S_WT;
                    end
                end
                S_WT: begin
                    r_s     <= n_s;
                    r_cnt   <= n_cnt;
                    r_wt    <= n_wt;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p_new  <= n_p_new;
                    r_p_best <= n_p_best;
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    if (n_better) begin
                        r_best_valid <= 1'b1;
                        r_best_idx   <= r_widx;
                        r_best_wt    <= r_wt;
                        r_best_s     <= r_s;
                        r_best_cnt   <= r_cnt;
                    end
                    if (last_worker) begin
                        r_state <= S_DONE;
                    end else begin
                        r_widx  <= r_widx + 1'b1;
                        r_state <= S_WT;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        if (cnt_we) begin
                            r_cnt_vld[r_best_idx] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `TGWA_ASSERT_NOW(a_best_has_speed, r_best_valid, r_best_s != '0,
        "Chosen worker has a zero score.")
    `TGWA_ASSERT_NOW(a_error_no_worker, r_out_valid && r_out.status != ST_OK,
        r_out.assigned_worker == '0, "Error word names a worker.")
    `TGWA_ASSERT_NEXT(a_done_delivers, r_state == S_DONE && out_free, r_out_valid,
        "Finished task did not present its word.")
    `TGWA_ASSERT_NOW(a_count_bound, cnt_we, cnt_wdata <= BATCH_MAX,
        "Pick count written above the batch bound.")

endmodule
